### rtl/hgcd_pkg.sv
package hgcd_pkg;

   localparam int ANGLE_FRAC_BITS = 28;
   localparam int DIST_FRAC_BITS  = 16;

   localparam int LAT_W    = 30;
   localparam int LON_W    = 31;
   localparam int DIST_W   = 34;
   localparam int RADIUS_W = 16;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd6371;
   localparam logic                REG_SPHERE_RADIUS = 1'b0;

   localparam logic [31:0] Q_ONE       = 32'h4000_0000;
   localparam logic [31:0] INV_PI_Q31  = 32'd683565276;
   localparam logic [31:0] PI_Q30      = 32'd3373259426;
   localparam logic [30:0] TAN_PI8_Q30 = 31'd444758426;
   localparam logic [31:0] PI4_Q30     = 32'd843314857;
   localparam logic [31:0] PI2_Q30     = 32'd1686629713;

   localparam int COS_STEPS  = 6;
   localparam int ATAN_STEPS = 11;
   localparam int SQRT_BITS  = 31;
   localparam int DIV_BITS   = 31;

   // Horner divisors as reciprocals: floor(n/d) = (n*R) >> S for n < 2^31
   localparam int COS_TC_SH [COS_STEPS] = '{39, 38, 37, 36, 35, 32};
   localparam logic [31:0] COS_TC_RCP [COS_STEPS] = '{
      32'(((64'd1 << 39) + 64'd131) / 64'd132),
      32'(((64'd1 << 38) + 64'd89) / 64'd90),
      32'(((64'd1 << 37) + 64'd55) / 64'd56),
      32'(((64'd1 << 36) + 64'd29) / 64'd30),
      32'(((64'd1 << 35) + 64'd11) / 64'd12),
      32'(((64'd1 << 32) + 64'd1) / 64'd2)};
   localparam int COS_TS_SH [COS_STEPS] = '{39, 38, 38, 37, 36, 34};
   localparam logic [31:0] COS_TS_RCP [COS_STEPS] = '{
      32'(((64'd1 << 39) + 64'd155) / 64'd156),
      32'(((64'd1 << 38) + 64'd109) / 64'd110),
      32'(((64'd1 << 38) + 64'd71) / 64'd72),
      32'(((64'd1 << 37) + 64'd41) / 64'd42),
      32'(((64'd1 << 36) + 64'd19) / 64'd20),
      32'(((64'd1 << 34) + 64'd5) / 64'd6)};

   // 1/(2k+1) in Q1.30, indexed by k
   localparam logic [30:0] ATAN_INV [ATAN_STEPS] = '{
      31'(64'h4000_0000 / 64'd1),  31'(64'h4000_0000 / 64'd3),
      31'(64'h4000_0000 / 64'd5),  31'(64'h4000_0000 / 64'd7),
      31'(64'h4000_0000 / 64'd9),  31'(64'h4000_0000 / 64'd11),
      31'(64'h4000_0000 / 64'd13), 31'(64'h4000_0000 / 64'd15),
      31'(64'h4000_0000 / 64'd17), 31'(64'h4000_0000 / 64'd19),
      31'(64'h4000_0000 / 64'd21)};
   localparam logic [30:0] ATAN_INIT = 31'(64'h4000_0000 / 64'd23);

   typedef struct packed {
      logic        swap;
      logic        zero;
      logic        big;
      logic [30:0] z;
   } atan_side_type;

   // (a*b) >> 30, rounded half away from zero
   function automatic logic signed [33:0] smul_q30(input logic signed [32:0] a,
                                                   input logic signed [32:0] b);
      logic [31:0] ma;
      logic [31:0] mb;
      logic [63:0] p;
      logic [33:0] m;
      ma = a[32] ? 32'(-a) : 32'(a);
      mb = b[32] ? 32'(-b) : 32'(b);
      p  = 64'(ma) * 64'(mb) + (64'd1 << 29);
      m  = 34'(p >> 30);
      return (a[32] ^ b[32]) ? -signed'(m) : signed'(m);
   endfunction

   // radians (ANGLE_FRAC_BITS) to 2^-32 turn
   function automatic logic [31:0] to_phase(input logic signed [31:0] v);
      logic [31:0] m;
      logic [63:0] p;
      logic [31:0] ph;
      m  = v[31] ? 32'(-v) : 32'(v);
      p  = 64'(m) * 64'(INV_PI_Q31) + (64'd1 << (ANGLE_FRAC_BITS - 1));
      ph = 32'(p >> ANGLE_FRAC_BITS);
      return v[31] ? 32'(-ph) : ph;
   endfunction

endpackage

### rtl/haversine_great_circle_distance.sv
// Throughput: one point pair per cycle; busy is always low.
// Most of the pipeline is in the one-bit-per-stage units: square root (31) and two dividers (31 each).
// Synchronous active-high reset clears the pipeline valids and sets the radius to 6371 km.
// The receiver cannot stall; each result is shown for exactly one cycle.
module haversine_great_circle_distance (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [hgcd_pkg::LAT_W-1:0]   req_first_latitude,
   input  logic signed [hgcd_pkg::LON_W-1:0]   req_first_longitude,
   input  logic signed [hgcd_pkg::LAT_W-1:0]   req_second_latitude,
   input  logic signed [hgcd_pkg::LON_W-1:0]   req_second_longitude,
   output logic                                rsp_strobe,
   output logic [hgcd_pkg::DIST_W-1:0]         rsp_distance_km,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [2:0]                          paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);
   import hgcd_pkg::*;

   localparam int DIST_SH = 30 - DIST_FRAC_BITS;

   logic [RADIUS_W-1:0] radius_ff;

   logic signed [31:0] lat1_ff, lat2_ff, dlat_ff, dlon_ff;
   logic               s1_vld_ff;
   logic [31:0]        ph_lat1_ff, ph_lat2_ff, ph_dlat_ff, ph_dlon_ff;
   logic               s2_vld_ff;

   logic signed [31:0] c_lat1, c_lat2, c_dlat, c_dlon;
   logic               cos_vld;

   logic signed [32:0] hlat_diff_in, hlon_diff_in;
   logic [30:0]        hlat_ff, hlon_ff;
   logic signed [31:0] m1_ff;
   logic               s3_vld_ff;

   logic signed [34:0] a_sum_in;
   logic [30:0]        a_in;
   logic [30:0]        a_ff;
   logic               s4_vld_ff;

   logic [30:0]        sqrt_a, sqrt_b;
   logic               sqrt_vld;

   logic               swap_in;
   logic [30:0]        num_ff, den_ff;
   atan_side_type      side5_ff;
   logic               s5_vld_ff;

   logic [30:0]        z_q;
   atan_side_type      side_d1;
   logic               d1_vld;

   logic [31:0]        mnum_ff, dden_ff;
   atan_side_type      side6_ff;
   logic               s6_vld_ff;

   logic [30:0]        w_q;
   atan_side_type      side_d2;
   logic               d2_vld;

   logic signed [31:0] w7_ff;
   atan_side_type      side7_ff;
   logic               s7_vld_ff;

   logic signed [31:0] w8_ff;
   logic [30:0]        w2_8_ff;
   atan_side_type      side8_ff;
   logic               s8_vld_ff;

   logic signed [31:0] t_ff    [ATAN_STEPS];
   logic signed [31:0] ws_ff   [ATAN_STEPS];
   logic [30:0]        w2s_ff  [ATAN_STEPS];
   atan_side_type      sides_ff[ATAN_STEPS];
   logic               vs_ff   [ATAN_STEPS];

   logic [31:0]        base_in;
   logic signed [33:0] r_ff;
   logic               r_swap_ff, r_zero_ff;
   logic               f1_vld_ff;

   logic signed [33:0] ang_in;
   logic [32:0]        ang2_ff;
   logic               f2_vld_ff;

   logic [49:0]        dprod_in;
   logic [DIST_W-1:0]  dist_ff;
   logic               out_vld_ff;

   // configuration port
   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_SPHERE_RADIUS) ? 32'(radius_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else if (psel && penable && pwrite && pready
                   && (paddr[2] == REG_SPHERE_RADIUS)) begin
         radius_ff <= pwdata[RADIUS_W-1:0];
      end
   end

   assign busy = 1'b0;

   // front end: differences, then phases
   always_ff @(posedge clock) begin
      lat1_ff    <= 32'(req_first_latitude);
      lat2_ff    <= 32'(req_second_latitude);
      dlat_ff    <= 32'(req_second_latitude) - 32'(req_first_latitude);
      dlon_ff    <= 32'(req_second_longitude) - 32'(req_first_longitude);
      ph_lat1_ff <= to_phase(lat1_ff);
      ph_lat2_ff <= to_phase(lat2_ff);
      ph_dlat_ff <= to_phase(dlat_ff);
      ph_dlon_ff <= to_phase(dlon_ff);
   end

   hgcd_cos u_cos_lat1 (
      .clock(clock), .reset(reset), .in_valid(s2_vld_ff), .phase(ph_lat1_ff),
      .out_valid(cos_vld), .cos_value(c_lat1));
   hgcd_cos u_cos_lat2 (
      .clock(clock), .reset(reset), .in_valid(s2_vld_ff), .phase(ph_lat2_ff),
      .out_valid(), .cos_value(c_lat2));
   hgcd_cos u_cos_dlat (
      .clock(clock), .reset(reset), .in_valid(s2_vld_ff), .phase(ph_dlat_ff),
      .out_valid(), .cos_value(c_dlat));
   hgcd_cos u_cos_dlon (
      .clock(clock), .reset(reset), .in_valid(s2_vld_ff), .phase(ph_dlon_ff),
      .out_valid(), .cos_value(c_dlon));

   // haversine term
   assign hlat_diff_in = 33'(signed'(Q_ONE)) - 33'(c_dlat);
   assign hlon_diff_in = 33'(signed'(Q_ONE)) - 33'(c_dlon);
   assign a_sum_in = 35'(signed'({1'b0, hlat_ff})) + 35'(smul_q30(33'(m1_ff), 33'(hlon_ff)));

   always_comb begin
      if (a_sum_in < 35'sd0) begin
         a_in = '0;
      end else if (a_sum_in > signed'({3'b000, Q_ONE})) begin
         a_in = 31'(Q_ONE);
      end else begin
         a_in = 31'(a_sum_in);
      end
   end

   always_ff @(posedge clock) begin
      hlat_ff <= hlat_diff_in[31:1];
      hlon_ff <= hlon_diff_in[31:1];
      m1_ff   <= 32'(smul_q30(33'(c_lat1), 33'(c_lat2)));
      a_ff    <= a_in;
   end

   hgcd_sqrt u_sqrt_a (
      .clock(clock), .reset(reset), .in_valid(s4_vld_ff), .radicand(a_ff),
      .out_valid(sqrt_vld), .root(sqrt_a));
   hgcd_sqrt u_sqrt_b (
      .clock(clock), .reset(reset), .in_valid(s4_vld_ff), .radicand(31'(Q_ONE) - a_ff),
      .out_valid(), .root(sqrt_b));

   // atan2: ratio of smaller over larger root
   assign swap_in = sqrt_a > sqrt_b;

   always_ff @(posedge clock) begin
      num_ff        <= swap_in ? sqrt_b : sqrt_a;
      den_ff        <= swap_in ? sqrt_a : sqrt_b;
      side5_ff.swap <= swap_in;
      side5_ff.zero <= (swap_in ? sqrt_a : sqrt_b) == 31'd0;
      side5_ff.big  <= 1'b0;
      side5_ff.z    <= '0;
   end

   hgcd_div u_div_ratio (
      .clock(clock), .reset(reset), .in_valid(s5_vld_ff),
      .num(32'(num_ff)), .den(32'(den_ff)), .in_side(side5_ff),
      .out_valid(d1_vld), .quot(z_q), .out_side(side_d1));

   // above tan(pi/8): fold through (z-1)/(z+1)
   always_ff @(posedge clock) begin
      mnum_ff       <= Q_ONE - 32'(z_q);
      dden_ff       <= 32'(z_q) + Q_ONE;
      side6_ff.swap <= side_d1.swap;
      side6_ff.zero <= side_d1.zero;
      side6_ff.big  <= z_q > TAN_PI8_Q30;
      side6_ff.z    <= z_q;
   end

   hgcd_div u_div_fold (
      .clock(clock), .reset(reset), .in_valid(s6_vld_ff),
      .num(mnum_ff), .den(dden_ff), .in_side(side6_ff),
      .out_valid(d2_vld), .quot(w_q), .out_side(side_d2));

   always_ff @(posedge clock) begin
      w7_ff    <= side_d2.big ? -signed'(32'(w_q)) : signed'(32'(side_d2.z));
      side7_ff <= side_d2;
      w8_ff    <= w7_ff;
      w2_8_ff  <= 31'(smul_q30(33'(w7_ff), 33'(w7_ff)));
      side8_ff <= side7_ff;
   end

   // arctan series, one Horner term per stage, k from 10 down to 0
   for (genvar i = 0; i < ATAN_STEPS; i++) begin : g_atan
      logic signed [31:0] t_prev;
      logic signed [31:0] w_prev;
      logic [30:0]        w2_prev;
      atan_side_type      side_prev;
      logic               v_prev;

      if (i == 0) begin : g_first
         assign t_prev    = signed'({1'b0, ATAN_INIT});
         assign w_prev    = w8_ff;
         assign w2_prev   = w2_8_ff;
         assign side_prev = side8_ff;
         assign v_prev    = s8_vld_ff;
      end else begin : g_next
         assign t_prev    = t_ff[i-1];
         assign w_prev    = ws_ff[i-1];
         assign w2_prev   = w2s_ff[i-1];
         assign side_prev = sides_ff[i-1];
         assign v_prev    = vs_ff[i-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vs_ff[i] <= 1'b0;
         end else begin
            vs_ff[i] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         t_ff[i]     <= 32'(34'(signed'({1'b0, ATAN_INV[ATAN_STEPS-1-i]}))
                            - smul_q30(33'(w2_prev), 33'(t_prev)));
         ws_ff[i]    <= w_prev;
         w2s_ff[i]   <= w2_prev;
         sides_ff[i] <= side_prev;
      end
   end

   assign base_in = sides_ff[ATAN_STEPS-1].big ? PI4_Q30 : 32'd0;

   always_comb begin
      if (r_zero_ff) begin
         ang_in = '0;
      end else if (r_swap_ff) begin
         ang_in = 34'(signed'({1'b0, PI2_Q30})) - r_ff;
      end else begin
         ang_in = r_ff;
      end
   end

   assign dprod_in = 50'(radius_ff) * 50'(ang2_ff) + (50'd1 << (DIST_SH - 1));

   always_ff @(posedge clock) begin
      r_ff      <= 34'(signed'({1'b0, base_in}))
                   + smul_q30(33'(ws_ff[ATAN_STEPS-1]), 33'(t_ff[ATAN_STEPS-1]));
      r_swap_ff <= sides_ff[ATAN_STEPS-1].swap;
      r_zero_ff <= sides_ff[ATAN_STEPS-1].zero;
      ang2_ff   <= {ang_in[31:0], 1'b0};
      dist_ff   <= DIST_W'(dprod_in >> DIST_SH);
   end

   // valid chain for the stages kept here
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         s4_vld_ff  <= 1'b0;
         s5_vld_ff  <= 1'b0;
         s6_vld_ff  <= 1'b0;
         s7_vld_ff  <= 1'b0;
         s8_vld_ff  <= 1'b0;
         f1_vld_ff  <= 1'b0;
         f2_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= start && !busy;
         s2_vld_ff  <= s1_vld_ff;
         s3_vld_ff  <= cos_vld;
         s4_vld_ff  <= s3_vld_ff;
         s5_vld_ff  <= sqrt_vld;
         s6_vld_ff  <= d1_vld;
         s7_vld_ff  <= d2_vld;
         s8_vld_ff  <= s7_vld_ff;
         f1_vld_ff  <= vs_ff[ATAN_STEPS-1];
         f2_vld_ff  <= f1_vld_ff;
         out_vld_ff <= f2_vld_ff;
      end
   end

   assign rsp_strobe      = out_vld_ff;
   assign rsp_distance_km = dist_ff;

endmodule

### rtl/hgcd_cos.sv
module hgcd_cos (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [31:0]        phase,
   output logic               out_valid,
   output logic signed [31:0] cos_value
);
   import hgcd_pkg::*;

   localparam logic signed [33:0] LIM = 34'(signed'({1'b0, Q_ONE}));

   logic [31:0]        p_in;
   logic signed [30:0] r_in;
   logic [29:0]        rmag_in;
   logic [62:0]        xprod_in;
   logic [31:0]        xmag_in;
   logic signed [31:0] x_in;

   logic signed [31:0] x1_ff;
   logic [1:0]         quad1_ff;
   logic               v1_ff;

   logic signed [31:0] xb_ff    [COS_STEPS+1];
   logic [30:0]        x2b_ff   [COS_STEPS+1];
   logic [1:0]         quadb_ff [COS_STEPS+1];
   logic [30:0]        tcb_ff   [COS_STEPS+1];
   logic [30:0]        tsb_ff   [COS_STEPS+1];
   logic               vb_ff    [COS_STEPS+1];

   logic signed [31:0] xa_ff    [COS_STEPS];
   logic [30:0]        x2a_ff   [COS_STEPS];
   logic [1:0]         quada_ff [COS_STEPS];
   logic [30:0]        pca_ff   [COS_STEPS];
   logic [30:0]        psa_ff   [COS_STEPS];
   logic               va_ff    [COS_STEPS];

   logic signed [33:0] tsf_ff;
   logic [30:0]        tcf_ff;
   logic [1:0]         quadf_ff;
   logic               vf_ff;

   logic signed [33:0] res_in;
   logic signed [31:0] cos_ff;
   logic               vo_ff;

   // quadrant and residue in [-pi/4, pi/4)
   assign p_in     = phase + 32'h2000_0000;
   assign r_in     = signed'({1'b0, p_in[29:0]}) - 31'sh2000_0000;
   assign rmag_in  = r_in[30] ? 30'(-r_in) : 30'(r_in);
   assign xprod_in = 63'(rmag_in) * 63'(PI_Q30) + (63'd1 << 30);
   assign xmag_in  = 32'(xprod_in >> 31);
   assign x_in     = r_in[30] ? -signed'(xmag_in) : signed'(xmag_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         vb_ff[0] <= 1'b0;
         vf_ff    <= 1'b0;
         vo_ff    <= 1'b0;
      end else begin
         v1_ff    <= in_valid;
         vb_ff[0] <= v1_ff;
         vf_ff    <= vb_ff[COS_STEPS];
         vo_ff    <= vf_ff;
      end
   end

   always_ff @(posedge clock) begin
      x1_ff       <= x_in;
      quad1_ff    <= p_in[31:30];
      xb_ff[0]    <= x1_ff;
      x2b_ff[0]   <= 31'(smul_q30(33'(x1_ff), 33'(x1_ff)));
      quadb_ff[0] <= quad1_ff;
      tcb_ff[0]   <= 31'(Q_ONE);
      tsb_ff[0]   <= 31'(Q_ONE);
      tsf_ff      <= smul_q30(33'(xb_ff[COS_STEPS]), 33'(tsb_ff[COS_STEPS]));
      tcf_ff      <= tcb_ff[COS_STEPS];
      quadf_ff    <= quadb_ff[COS_STEPS];
      cos_ff      <= 32'(res_in);
   end

   for (genvar j = 0; j < COS_STEPS; j++) begin : g_step
      always_ff @(posedge clock) begin
         if (reset) begin
            va_ff[j]   <= 1'b0;
            vb_ff[j+1] <= 1'b0;
         end else begin
            va_ff[j]   <= vb_ff[j];
            vb_ff[j+1] <= va_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         xa_ff[j]      <= xb_ff[j];
         x2a_ff[j]     <= x2b_ff[j];
         quada_ff[j]   <= quadb_ff[j];
         pca_ff[j]     <= 31'(smul_q30(33'(x2b_ff[j]), 33'(tcb_ff[j])));
         psa_ff[j]     <= 31'(smul_q30(33'(x2b_ff[j]), 33'(tsb_ff[j])));
         xb_ff[j+1]    <= xa_ff[j];
         x2b_ff[j+1]   <= x2a_ff[j];
         quadb_ff[j+1] <= quada_ff[j];
         tcb_ff[j+1]   <= 31'(Q_ONE)
                          - 31'((64'(pca_ff[j]) * 64'(COS_TC_RCP[j])) >> COS_TC_SH[j]);
         tsb_ff[j+1]   <= 31'(Q_ONE)
                          - 31'((64'(psa_ff[j]) * 64'(COS_TS_RCP[j])) >> COS_TS_SH[j]);
      end
   end

   always_comb begin
      case (quadf_ff)
         2'd0:    res_in = 34'(signed'({1'b0, tcf_ff}));
         2'd1:    res_in = -tsf_ff;
         2'd2:    res_in = -34'(signed'({1'b0, tcf_ff}));
         default: res_in = tsf_ff;
      endcase
      if (res_in > LIM) begin
         res_in = LIM;
      end else if (res_in < -LIM) begin
         res_in = -LIM;
      end
   end

   assign out_valid = vo_ff;
   assign cos_value = cos_ff;

endmodule

### rtl/hgcd_sqrt.sv
module hgcd_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [30:0] radicand,
   output logic        out_valid,
   output logic [30:0] root
);
   import hgcd_pkg::*;

   // floor(sqrt(radicand * 2^30)), one root bit per stage
   logic [30:0] root_ff [SQRT_BITS];
   logic [60:0] rem_ff  [SQRT_BITS];
   logic        v_ff    [SQRT_BITS];

   for (genvar j = 0; j < SQRT_BITS; j++) begin : g_bit
      localparam int BIT = SQRT_BITS - 1 - j;
      logic [30:0] root_prev;
      logic [60:0] rem_prev;
      logic        v_prev;
      logic [62:0] trial_in;
      logic        ge_in;

      if (j == 0) begin : g_first
         assign root_prev = '0;
         assign rem_prev  = {radicand, 30'd0};
         assign v_prev    = in_valid;
      end else begin : g_next
         assign root_prev = root_ff[j-1];
         assign rem_prev  = rem_ff[j-1];
         assign v_prev    = v_ff[j-1];
      end

      assign trial_in = (63'(root_prev) << (BIT + 1)) + (63'd1 << (2 * BIT));
      assign ge_in    = 63'(rem_prev) >= trial_in;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else begin
            v_ff[j] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[j]  <= ge_in ? 61'(63'(rem_prev) - trial_in) : rem_prev;
         root_ff[j] <= ge_in ? (root_prev | (31'd1 << BIT)) : root_prev;
      end
   end

   assign out_valid = v_ff[SQRT_BITS-1];
   assign root      = root_ff[SQRT_BITS-1];

endmodule

### rtl/hgcd_div.sv
module hgcd_div (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [31:0]             num,
   input  logic [31:0]             den,
   input  hgcd_pkg::atan_side_type in_side,
   output logic                    out_valid,
   output logic [30:0]             quot,
   output hgcd_pkg::atan_side_type out_side
);
   import hgcd_pkg::*;

   // floor(num * 2^30 / den) for num <= den, one quotient bit per stage
   logic [31:0]   rem_ff  [DIV_BITS];
   logic [31:0]   den_ff  [DIV_BITS];
   logic [30:0]   q_ff    [DIV_BITS];
   atan_side_type side_ff [DIV_BITS];
   logic          v_ff    [DIV_BITS];

   for (genvar j = 0; j < DIV_BITS; j++) begin : g_bit
      logic [32:0]   rin;
      logic [31:0]   den_prev;
      logic [30:0]   q_prev;
      atan_side_type side_prev;
      logic          v_prev;
      logic          ge_in;

      if (j == 0) begin : g_first
         assign rin       = {1'b0, num};
         assign den_prev  = den;
         assign q_prev    = '0;
         assign side_prev = in_side;
         assign v_prev    = in_valid;
      end else begin : g_next
         assign rin       = {rem_ff[j-1], 1'b0};
         assign den_prev  = den_ff[j-1];
         assign q_prev    = q_ff[j-1];
         assign side_prev = side_ff[j-1];
         assign v_prev    = v_ff[j-1];
      end

      assign ge_in = rin >= {1'b0, den_prev};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else begin
            v_ff[j] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[j]  <= ge_in ? 32'(rin - {1'b0, den_prev}) : 32'(rin);
         den_ff[j]  <= den_prev;
         q_ff[j]    <= {q_prev[29:0], ge_in};
         side_ff[j] <= side_prev;
      end
   end

   assign out_valid = v_ff[DIV_BITS-1];
   assign quot      = q_ff[DIV_BITS-1];
   assign out_side  = side_ff[DIV_BITS-1];

endmodule

### test/haversine_great_circle_distance_tb.sv
module haversine_great_circle_distance_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import hgcd_pkg::*;

   localparam longint ONE = 64'sd1 << 30;
   localparam logic [2:0] ADDR_RADIUS = {REG_SPHERE_RADIUS, 2'b00};
   localparam logic [2:0] ADDR_UNUSED = 3'd4;
   localparam int DRAIN_CYCLES = 160;
   localparam int RANDOM_PAIRS = 650;

   typedef struct packed {
      logic signed [LAT_W-1:0] lat1;
      logic signed [LON_W-1:0] lon1;
      logic signed [LAT_W-1:0] lat2;
      logic signed [LON_W-1:0] lon2;
      logic                    known;
      logic [DIST_W-1:0]       want_km;
   } pair_row_type;

   // directed pairs; want_km is typed in only where obvious
   pair_row_type dir_tab [11] = '{
      '{30'sd0, 31'sd0, 30'sd0, 31'sd0, 1'b1, 34'd0},
      '{30'sd300000000, -31'sd500000000, 30'sd300000000, -31'sd500000000, 1'b1, 34'd0},
      '{30'sd421657428, 31'sd0, -30'sd421657428, 31'sd0, 1'b0, 34'd0},
      '{30'sd0, 31'sd843314857, 30'sd0, -31'sd843314857, 1'b0, 34'd0},
      '{30'sd0, 31'sd0, 30'sd0, 31'sd843314857, 1'b0, 34'd0},
      '{30'sd421657428, 31'sd0, -30'sd421657428, 31'sd843314857, 1'b0, 34'd0},
      '{30'h1FFF_FFFF, 31'h3FFF_FFFF, 30'h2000_0000, 31'h4000_0000, 1'b0, 34'd0},
      '{-30'sd1, -31'sd1, -30'sd1, -31'sd1, 1'b1, 34'd0},
      '{30'sd0, 31'sd0, 30'sd0, 31'sd1, 1'b0, 34'd0},
      '{30'sd2000, -31'sd7000, -30'sd1234567, 31'sd98765432, 1'b0, 34'd0},
      '{30'h2000_0000, 31'h4000_0000, 30'h1FFF_FFFF, 31'h3FFF_FFFF, 1'b0, 34'd0}};

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic signed [LAT_W-1:0]  req_first_latitude = '0;
   logic signed [LON_W-1:0]  req_first_longitude = '0;
   logic signed [LAT_W-1:0]  req_second_latitude = '0;
   logic signed [LON_W-1:0]  req_second_longitude = '0;
   logic                     rsp_strobe;
   logic [DIST_W-1:0]        rsp_distance_km;
   logic                     psel = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite = 1'b0;
   logic [2:0]               paddr = '0;
   logic [31:0]              pwdata = '0;
   logic [31:0]              prdata;
   logic                     pready;

   logic [DIST_W-1:0]   pending_dist [$];
   logic [RADIUS_W-1:0] radius_km = RADIUS_RESET;
   int                  mismatches = 0;
   bit                  no_idle = 1'b0;

   haversine_great_circle_distance u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_first_latitude(req_first_latitude), .req_first_longitude(req_first_longitude),
      .req_second_latitude(req_second_latitude),
      .req_second_longitude(req_second_longitude),
      .rsp_strobe(rsp_strobe), .rsp_distance_km(rsp_distance_km),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready));

   always #6 clock = ~clock;

   initial begin
      #5ms;
      $display("== FAIL ==");
      $finish;
   end

   function automatic longint unsigned magn(input longint a);
      return a < 0 ? longint'(-a) : a;
   endfunction

   // product shifted right, rounded half away from zero
   function automatic longint rmul(input longint a, input longint b, input int sh);
      longint unsigned m;
      m = magn(a) * magn(b);
      m = (m + (64'd1 << (sh - 1))) >> sh;
      return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
   endfunction

   function automatic logic [31:0] turn_of(input longint v);
      longint unsigned m;
      logic [31:0] p;
      m = magn(v) * longint'(INV_PI_Q31);
      m = (m + (64'd1 << (ANGLE_FRAC_BITS - 1))) >> ANGLE_FRAC_BITS;
      p = m[31:0];
      return v < 0 ? -p : p;
   endfunction

   function automatic longint cos_turn(input logic [31:0] ph);
      logic [31:0] p;
      longint r, x, x2, tc, ts, res;
      p = ph + 32'h2000_0000;
      r = longint'({34'd0, p[29:0]}) - 64'sh2000_0000;
      x = rmul(r, longint'(PI_Q30), 31);
      x2 = rmul(x, x, 30);
      tc = ONE;
      ts = ONE;
      for (int k = 6; k >= 1; k--) begin
         tc = ONE - rmul(x2, tc, 30) / longint'((2 * k - 1) * (2 * k));
         ts = ONE - rmul(x2, ts, 30) / longint'((2 * k) * (2 * k + 1));
      end
      ts = rmul(x, ts, 30);
      case (p[31:30])
         2'd0: res = tc;
         2'd1: res = -ts;
         2'd2: res = -tc;
         default: res = ts;
      endcase
      if (res > ONE) res = ONE;
      if (res < -ONE) res = -ONE;
      return res;
   endfunction

   function automatic longint unsigned floor_sqrt(input longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint half_angle(input longint y, input longint x);
      bit swap;
      longint num, den, z, w, w2, t, base, r;
      swap = y > x;
      num = swap ? x : y;
      den = swap ? y : x;
      base = 0;
      if (den == 0) return 0;
      z = (num << 30) / den;
      if (z > longint'(TAN_PI8_Q30)) begin
         w = ((z - ONE) * ONE) / (z + ONE);
         base = longint'(PI4_Q30);
      end else begin
         w = z;
      end
      w2 = rmul(w, w, 30);
      t = ONE / 23;
      for (int k = 10; k >= 0; k--) t = ONE / longint'(2 * k + 1) - rmul(w2, t, 30);
      r = base + rmul(w, t, 30);
      return swap ? longint'(PI2_Q30) - r : r;
   endfunction

   function automatic logic [DIST_W-1:0] dist_predict(input pair_row_type pr,
                                                      input logic [RADIUS_W-1:0] rad);
      longint la1, la2, lo1, lo2, c1, c2, hlat, hlon, a, ang;
      longint unsigned d;
      la1 = longint'(pr.lat1);
      la2 = longint'(pr.lat2);
      lo1 = longint'(pr.lon1);
      lo2 = longint'(pr.lon2);
      c1 = cos_turn(turn_of(la1));
      c2 = cos_turn(turn_of(la2));
      hlat = (ONE - cos_turn(turn_of(la2 - la1))) / 2;
      hlon = (ONE - cos_turn(turn_of(lo2 - lo1))) / 2;
      a = hlat + rmul(rmul(c1, c2, 30), hlon, 30);
      if (a < 0) a = 0;
      if (a > ONE) a = ONE;
      ang = 2 * half_angle(longint'(floor_sqrt(a << 30)),
                           longint'(floor_sqrt((ONE - a) << 30)));
      d = longint'(rad) * ang;
      d = (d + (64'd1 << (29 - DIST_FRAC_BITS))) >> (30 - DIST_FRAC_BITS);
      return d[DIST_W-1:0];
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_dist.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected distance %0d", rsp_distance_km);
         end else begin
            logic [DIST_W-1:0] want;
            want = pending_dist.pop_front();
            if (want !== rsp_distance_km) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("distance mismatch: expected %0d got %0d", want, rsp_distance_km);
            end
         end
      end
   end

   task automatic send_pair(input pair_row_type pr);
      if (!no_idle && $urandom_range(99) < 14) begin
         start <= 1'b0;
         @(posedge clock);
         while ($urandom_range(3) == 0) @(posedge clock);
      end
      start <= 1'b1;
      req_first_latitude <= pr.lat1;
      req_first_longitude <= pr.lon1;
      req_second_latitude <= pr.lat2;
      req_second_longitude <= pr.lon2;
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
      pending_dist = {pending_dist, (pr.known ? pr.want_km : dist_predict(pr, radius_km))};
   endtask

   task automatic csr_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(negedge clock);
      while (!pready) @(negedge clock);
      if (!wr && addr == ADDR_RADIUS && prdata !== 32'(radius_km)) begin
         mismatches++;
         if (mismatches <= 10)
            $display("radius readback: expected %0d got %0d", radius_km, prdata);
      end
      @(posedge clock);
      if (wr && addr == ADDR_RADIUS) radius_km = data[RADIUS_W-1:0];
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (pending_dist.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic pair_row_type random_pair(input int mode);
      pair_row_type pr;
      pr.known = 1'b0;
      pr.want_km = '0;
      if (mode == 0) begin
         // raw bit patterns, out-of-range angles included
         pr.lat1 = LAT_W'($urandom);
         pr.lon1 = LON_W'($urandom);
         pr.lat2 = LAT_W'($urandom);
         pr.lon2 = LON_W'($urandom);
      end else begin
         pr.lat1 = LAT_W'(int'($urandom_range(843314856)) - 421657428);
         pr.lon1 = LON_W'(int'($urandom_range(1686629714)) - 843314857);
         if (mode == 1) begin
            // nearby points
            pr.lat2 = LAT_W'(int'(pr.lat1) + int'($urandom_range(2000000)) - 1000000);
            pr.lon2 = LON_W'(int'(pr.lon1) + int'($urandom_range(2000000)) - 1000000);
         end else if (mode == 2) begin
            // close to antipodal
            pr.lat2 = LAT_W'(-int'(pr.lat1) + int'($urandom_range(2000)) - 1000);
            pr.lon2 = LON_W'(int'(pr.lon1) + (pr.lon1 < 0 ? 843314857 : -843314857)
                             + int'($urandom_range(2000)) - 1000);
         end else begin
            pr.lat2 = LAT_W'(int'($urandom_range(843314856)) - 421657428);
            pr.lon2 = LON_W'(int'($urandom_range(1686629714)) - 843314857);
         end
      end
      return pr;
   endfunction

   initial begin
      logic [15:0] radius_set [5];
      int n;
      radius_set = '{16'd1, 16'd65535, 16'd0, 16'd6371, 16'd0};
      radius_set[4] = 16'($urandom_range(65535));
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_access(1'b0, ADDR_RADIUS, 32'd0);
      foreach (dir_tab[i]) send_pair(dir_tab[i]);
      n = 0;
      for (int ph = 0; ph < 6; ph++) begin
         if (ph > 0) begin
            wait_idle();
            // upper bits must be dropped; the unused address must be ignored
            csr_access(1'b1, ADDR_RADIUS,
                       {16'($urandom_range(65535, 1)), radius_set[ph-1]});
            csr_access(1'b1, ADDR_UNUSED, $urandom);
            csr_access(1'b0, ADDR_RADIUS, 32'd0);
            send_pair(dir_tab[5]);
            send_pair(dir_tab[3]);
         end
         for (int i = 0; i < RANDOM_PAIRS / 6; i++) begin
            no_idle = (n >= 200 && n < 320);
            send_pair(random_pair($urandom_range(9) < 2 ? 0 : $urandom_range(3, 1)));
            n++;
         end
      end
      no_idle = 1'b0;
      wait_idle();
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

### haversine_great_circle_distance.f
rtl/hgcd_pkg.sv
rtl/hgcd_cos.sv
rtl/hgcd_sqrt.sv
rtl/hgcd_div.sv
rtl/haversine_great_circle_distance.sv
test/haversine_great_circle_distance_tb.sv
